>>> rtl/core/sse_pkg.sv
// Package for the selection sort engine: payload types and sizing constants.
// No dependencies.
package sse_pkg;
   localparam int MAX_ELEMENTS = 64;
   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int FIFO_DEPTH = 2;

   typedef struct packed {
      logic signed [31:0] value;
      logic               is_last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               end_of_set;
      logic               overflowed;
   } rsp_type;
endpackage

>>> rtl/core/sse_front.sv
// Front end: accepts input transactions into a short queue for the back end.
// Depends on sse_pkg.
module sse_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  sse_pkg::req_type req_data,
   output logic            q_valid,
   input  logic            q_take,
   output sse_pkg::req_type q_data
);
   sse_pkg::req_type mem_ff [sse_pkg::FIFO_DEPTH];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign req_full = (cnt_ff == 2'(sse_pkg::FIFO_DEPTH));
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = mem_ff[rd_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_take && q_valid;

   always_comb begin
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      wr_in  = do_push ? ~wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= req_data;
      end
   end
endmodule

>>> rtl/core/sse_back.sv
// Back end: stores elements, sorts them by selection sort and emits results.
// Depends on sse_pkg.
module sse_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_take,
   input  sse_pkg::req_type q_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sse_pkg::rsp_type rsp_data
);
   localparam int IW = sse_pkg::IDX_W;
   localparam int CW = sse_pkg::CNT_W;
   localparam logic [2:0] ST_LOAD = 3'd0, ST_RDP = 3'd1, ST_SCAN = 3'd2,
      ST_SWAP = 3'd3, ST_EMIT = 3'd4, ST_EWAIT = 3'd5;

   logic signed [31:0] store [sse_pkg::MAX_ELEMENTS];
   logic [2:0] st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in, pos_ff, pos_in, scan_ff, scan_in, best_ff, best_in;
   logic ovf_ff, ovf_in;
   logic signed [31:0] bestv_ff, bestv_in, posv_ff, posv_in, rd_ff;
   logic [CW-1:0] raddr;
   logic full_ff, full_in;
   sse_pkg::rsp_type out_ff, out_in;
   logic we;
   logic [CW-1:0] waddr;
   logic signed [31:0] wdata;
   // Emit phase runs one read ahead: rd_ff is the registered read of raddr.
   logic emit_rd_ff, emit_rd_in;

   assign rsp_empty = !full_ff;
   assign rsp_data  = out_ff;
   assign q_take    = (st_ff == ST_LOAD);

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; pos_in = pos_ff; scan_in = scan_ff;
      best_in = best_ff; ovf_in = ovf_ff; bestv_in = bestv_ff; posv_in = posv_ff;
      full_in = full_ff && !rsp_pop; out_in = out_ff; emit_rd_in = 1'b0;
      we = 1'b0; waddr = cnt_ff; wdata = q_data.value; raddr = pos_ff;
      case (st_ff)
         ST_LOAD: begin
            if (q_valid) begin
               if (cnt_ff < CW'(sse_pkg::MAX_ELEMENTS)) begin
                  we = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (q_data.is_last) begin
                  pos_in = '0;
                  st_in = ST_RDP;
               end
            end
         end
         ST_RDP: begin
            // Read data for store[pos] arrives next cycle.
            if (pos_ff + 1'b1 >= cnt_ff) begin
               pos_in = '0;
               st_in = (cnt_ff == '0) ? ST_LOAD : ST_EMIT;
               if (cnt_ff == '0) ovf_in = 1'b0;
            end else begin
               raddr = pos_ff;
               best_in = pos_ff;
               scan_in = pos_ff;
               st_in = ST_SCAN;
               bestv_in = 32'sh7fffffff;
            end
         end
         ST_SCAN: begin
            // rd_ff holds store[scan_ff].
            if (scan_ff == pos_ff) begin
               posv_in = rd_ff; bestv_in = rd_ff; best_in = pos_ff;
            end else if (rd_ff < bestv_ff) begin
               bestv_in = rd_ff; best_in = scan_ff;
            end
            if (scan_ff + 1'b1 >= cnt_ff) begin
               st_in = ST_SWAP;
               raddr = pos_ff;
            end else begin
               raddr = scan_ff + 1'b1;
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_SWAP: begin
            we = 1'b1; waddr = best_ff; wdata = posv_ff;
            pos_in = pos_ff + 1'b1;
            st_in = ST_EWAIT;
         end
         ST_EWAIT: begin
            we = 1'b1; waddr = pos_ff - 1'b1; wdata = bestv_ff;
            raddr = pos_ff;
            st_in = ST_RDP;
         end
         ST_EMIT: begin
            raddr = pos_ff;
            if (!emit_rd_ff) begin
               if (!full_in) emit_rd_in = 1'b1;
            end else begin
               full_in = 1'b1;
               out_in.sorted_value = rd_ff;
               out_in.end_of_set = (pos_ff + 1'b1 == cnt_ff);
               out_in.overflowed = ovf_ff;
               if (pos_ff + 1'b1 == cnt_ff) begin
                  st_in = ST_LOAD; cnt_in = '0; ovf_in = 1'b0; pos_in = '0;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         default: st_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_LOAD; cnt_ff <= '0; ovf_ff <= 1'b0; full_ff <= 1'b0;
         emit_rd_ff <= 1'b0; pos_ff <= '0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; ovf_ff <= ovf_in; full_ff <= full_in;
         pos_ff <= pos_in;
         emit_rd_ff <= emit_rd_in;
      end
      scan_ff <= scan_in; best_ff <= best_in; bestv_ff <= bestv_in;
      posv_ff <= posv_in;
      out_ff <= out_in;
      if (we) store[waddr[IW-1:0]] <= wdata;
      rd_ff <= store[raddr[IW-1:0]];
   end
endmodule

>>> rtl/core/selection_sort_engine_unit.sv
// Selection sort engine top level: joins the input queue and the sort back end.
// Depends on sse_pkg, sse_front and sse_back.
// Elements are taken one per cycle until a transaction marked last; the set of
// n stored elements is then sorted, each pass reading the unsorted tail from the
// store one entry a cycle, and emitted one by one as the output register frees.
// Input stalls once the two-entry queue fills during the sort and the emit. The
// store holds 64 elements; more are dropped.
module selection_sort_engine_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  sse_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sse_pkg::rsp_type rsp_data
);
   logic q_valid, q_take;
   sse_pkg::req_type q_data;

   sse_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .q_valid, .q_take, .q_data
   );

   sse_back u_back (
      .clock, .reset, .q_valid, .q_take, .q_data,
      .rsp_empty, .rsp_pop, .rsp_data
   );
endmodule

>>> verif/tb.sv
// Testbench for selection_sort_engine_unit: drives sets of signed values and checks the
// sorted output against a scoreboard model of the sort, with random idling on both sides.
// Depends on sse_pkg and the RTL of the engine.
`timescale 1ns / 100ps

class sort_scoreboard;
   logic signed [31:0] open_set[$];
   bit                 dropped;
   sse_pkg::rsp_type   sorted_queue[$];
   int                 errors;

   function void note_input(sse_pkg::req_type item);
      logic signed [31:0] tmp;
      int best;
      if (open_set.size() < sse_pkg::MAX_ELEMENTS) open_set.push_back(item.value);
      else dropped = 1;
      if (!item.is_last) return;
      for (int p = 0; p + 1 < open_set.size(); p++) begin
         best = p;
         for (int s = p + 1; s < open_set.size(); s++)
            if (open_set[s] < open_set[best]) best = s;
         tmp = open_set[p];
         open_set[p] = open_set[best];
         open_set[best] = tmp;
      end
      foreach (open_set[k]) begin
         sse_pkg::rsp_type r;
         r.sorted_value = open_set[k];
         r.end_of_set = (k == open_set.size() - 1);
         r.overflowed = dropped;
         sorted_queue.push_back(r);
      end
      open_set.delete();
      dropped = 0;
   endfunction

   function void check_result(sse_pkg::rsp_type got);
      sse_pkg::rsp_type exp;
      if (sorted_queue.size() == 0) begin
         $error("result with no expectation: %h", got);
         errors++;
         return;
      end
      exp = sorted_queue.pop_front();
      if (got.sorted_value !== exp.sorted_value) begin
         $error("sorted_value expected %0d actual %0d", exp.sorted_value, got.sorted_value);
         errors++;
      end
      if (got.end_of_set !== exp.end_of_set) begin
         $error("end_of_set expected %0d actual %0d", exp.end_of_set, got.end_of_set);
         errors++;
      end
      if (got.overflowed !== exp.overflowed) begin
         $error("overflowed expected %0d actual %0d", exp.overflowed, got.overflowed);
         errors++;
      end
   endfunction
endclass

module tb;
   logic             clock = 0;
   logic             reset = 1;
   logic             req_push = 0;
   logic             req_full;
   sse_pkg::req_type req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop = 0;
   sse_pkg::rsp_type rsp_data;

   sort_scoreboard board = new();
   bit  calm = 0;
   bit  hold_off = 0;
   int  quiet_cycles = 0;
   localparam int QUIET_LIMIT = 40000;

   selection_sort_engine_unit dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_push && !req_full) board.note_input(req_data);
      if (!reset && rsp_pop && !rsp_empty) board.check_result(rsp_data);
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || hold_off) rsp_pop <= 0;
      else rsp_pop <= calm || ($urandom_range(99) >= 32);
   end

   task automatic send_element(logic signed [31:0] v, bit last);
      while (!calm && $urandom_range(99) < 32) begin
         req_push <= 0;
         @(posedge clock);
      end
      req_push <= 1;
      req_data <= '{value: v, is_last: last};
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_set(int n, bit extremes);
      logic signed [31:0] v;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: v = $urandom_range(7) - 4;
            1: v = extremes ? 32'sh8000_0000 : $urandom_range(3);
            2: v = extremes ? 32'sh7fff_ffff : $urandom_range(3);
            default: v = $urandom;
         endcase
         send_element(v, i == n - 1);
      end
   endtask

   task automatic drain();
      req_push <= 0;
      @(posedge clock);
      while (board.sorted_queue.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_element(32'sh7fff_ffff, 1);
      send_element(32'sh8000_0000, 1);
      send_element(5, 0);
      send_element(5, 0);
      send_element(-5, 0);
      send_element(32'sh8000_0000, 0);
      send_element(32'sh7fff_ffff, 1);
      send_element(0, 0);
      send_element(-1, 0);
      send_element(32'sh5555_5555, 0);
      send_element(32'shaaaa_aaaa, 1);
      send_set(3, 1);
      send_set(2, 0);
      drain();
      send_set(67, 1);
      hold_off <= 1;
      fork
         begin
            repeat (3000) @(posedge clock);
            hold_off <= 0;
         end
         send_set(8, 0);
      join
      drain();
      calm <= 1;
      for (int s = 0; s < 10; s++) send_set($urandom_range(1, 6), 0);
      calm <= 0;
      for (int s = 0; s < 8; s++) begin
         int n;
         n = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
         send_set(n, $urandom_range(1));
         if ($urandom_range(9) == 0) drain();
      end
      send_set(64, 1);
      drain();
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.sorted_queue.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
